// ===== rtl/assert_macros.svh =====
// Assertion helpers used by alpha_uncomposite_background_core to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AUC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AUC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/auc_pkg.sv =====
`default_nettype none

package auc_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned LANES  = 4;
  localparam int unsigned COLORS = 3;
  localparam int unsigned REM_W  = 17;
  localparam int unsigned QUO_W  = 9;
  localparam int unsigned DVS_W  = 9;
  localparam int unsigned CELLS  = QUO_W;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  localparam int unsigned LANE_ALPHA = 3;

  // Work item carried down the divider chain. Lanes 0..2 are red, green and
  // blue, lane 3 is alpha.
  typedef struct packed {
    logic [LANES-1:0][REM_W-1:0]  rem;
    logic [LANES-1:0][QUO_W-1:0]  quo;
    logic [DVS_W-1:0]             dvs;
    logic                         opaque;
    logic [COLORS-1:0][CH_W-1:0]  comp;
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/auc_prep.sv =====
`default_nettype none

module auc_prep (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [63:0]           data_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output auc_pkg::stage_t            data_o
);

  logic [auc_pkg::LANES-1:0][auc_pkg::CH_W-1:0]   c_in;
  logic [auc_pkg::LANES-1:0][auc_pkg::CH_W-1:0]   f_in;
  logic [auc_pkg::LANES-1:0][15:0]                prod_c;
  logic [auc_pkg::LANES-1:0][15:0]                prod_f;
  logic [auc_pkg::LANES-1:0][16:0]                diff;
  logic [auc_pkg::LANES-1:0][15:0]                num;
  logic [auc_pkg::CH_W-1:0]                       fa;
  logic [auc_pkg::CH_W-1:0]                       den;
  auc_pkg::stage_t                                data_d;
  auc_pkg::stage_t                                data_q;
  logic                                           valid_q;

  assign fa  = data_i[63:56];
  assign den = auc_pkg::CH_MAX - fa;

  // The alpha lane has the same form as a color lane with the foreground
  // value tied to full scale: 255*ca - fa*255.
  always_comb begin
    for (int l = 0; l < auc_pkg::LANES; l++) begin
      c_in[l] = data_i[l*8 +: 8];
      if (l == auc_pkg::LANE_ALPHA) begin
        f_in[l] = auc_pkg::CH_MAX;
      end else begin
        f_in[l] = data_i[32 + l*8 +: 8];
      end
    end
  end

  always_comb begin
    data_d = '0;
    for (int l = 0; l < auc_pkg::LANES; l++) begin
      prod_c[l] = {c_in[l], 8'h00} - {8'h00, c_in[l]};
      prod_f[l] = 16'(fa) * 16'(f_in[l]);
      diff[l]   = {1'b0, prod_c[l]} - {1'b0, prod_f[l]};
      // A negative numerator rounds to zero, as does a zero numerator.
      num[l]    = diff[l][16] ? 16'h0000 : diff[l][15:0];
      // Round to nearest: floor((2n + d) / 2d).
      data_d.rem[l] = {num[l], 1'b0} + {9'h000, den};
    end
    data_d.dvs    = {den, 1'b0};
    data_d.opaque = (fa == auc_pkg::CH_MAX);
    for (int k = 0; k < auc_pkg::COLORS; k++) begin
      data_d.comp[k] = data_i[k*8 +: 8];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/auc_cell.sv =====
`default_nettype none

module auc_cell #(
  parameter int unsigned Shift = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire auc_pkg::stage_t       data_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output auc_pkg::stage_t            data_o
);

  logic [auc_pkg::REM_W-1:0] dvs_sh;
  auc_pkg::stage_t           data_d;
  auc_pkg::stage_t           data_q;
  logic                      valid_q;

  assign dvs_sh = {{(auc_pkg::REM_W - auc_pkg::DVS_W){1'b0}}, data_i.dvs} << Shift;

  // One restoring step per lane: this cell decides quotient bit Shift.
  always_comb begin
    data_d = data_i;
    for (int l = 0; l < auc_pkg::LANES; l++) begin
      if (data_i.rem[l] >= dvs_sh) begin
        data_d.rem[l]        = data_i.rem[l] - dvs_sh;
        data_d.quo[l][Shift] = 1'b1;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/alpha_uncomposite_background_core.sv =====
// Inverse over compositing for RGBA8 pixels: recovers the background pixel
// from a composite pixel and the foreground that was blended over it.
//
// Input stream (s_axis): one transfer carries the composite and foreground
// pixels. Output stream (m_axis): one transfer carries the background pixel.
// Every input transfer gives exactly one output transfer, in order.
//
// A front stage forms the rounded numerators and the divisor, then a chain
// of nine division cells resolves one quotient bit each, from the overflow
// bit down to bit 0; the last cell doubles as the output register.
// A pixel passes the front stage register and then all nine cell registers
// before it can leave. The block takes one pixel in every cycle while the
// output is not stalled.
//
// When the receiver holds m_axis_tready low, the chain fills up behind the
// output and s_axis_tready falls once every stage holds a pixel; up to ten
// pixels are in flight. Reset empties the chain; no pixel survives it.
// A foreground alpha of 255 passes the composite color with alpha 0.
`default_nettype none

`include "assert_macros.svh"

module alpha_uncomposite_background_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // comp_red, comp_green, comp_blue, comp_alpha, fg_red, fg_green, fg_blue,
  // fg_alpha, 8 bits each from the lowest bit up.
  input  wire logic [63:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // bg_red, bg_green, bg_blue, bg_alpha, 8 bits each from the lowest bit up.
  output logic [31:0]       m_axis_tdata_o
);

  auc_pkg::stage_t                     pipe [0:auc_pkg::CELLS];
  logic [auc_pkg::CELLS:0]             pipe_valid;
  logic [auc_pkg::CELLS+1:0]           pipe_ready;
  auc_pkg::stage_t                     tail;
  logic [auc_pkg::LANES-1:0][7:0]      bg;
  logic [auc_pkg::REM_W-1:0]           tail_dvs_ext;

  auc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (pipe_ready[0]),
    .data_i  (s_axis_tdata_i),
    .valid_o (pipe_valid[0]),
    .ready_i (pipe_ready[1]),
    .data_o  (pipe[0])
  );

  for (genvar k = 0; k < auc_pkg::CELLS; k++) begin : g_cell
    auc_cell #(
      .Shift (auc_pkg::QUO_W - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pipe_valid[k]),
      .ready_o (pipe_ready[k+1]),
      .data_i  (pipe[k]),
      .valid_o (pipe_valid[k+1]),
      .ready_i (pipe_ready[k+2]),
      .data_o  (pipe[k+1])
    );
  end

  assign pipe_ready[auc_pkg::CELLS+1] = m_axis_tready_i;
  assign s_axis_tready_o              = pipe_ready[0];

  assign tail = pipe[auc_pkg::CELLS];

  assign tail_dvs_ext = {{(auc_pkg::REM_W - auc_pkg::DVS_W){1'b0}}, tail.dvs};

  // A set overflow bit means the quotient reached 256 and saturates.
  always_comb begin
    for (int l = 0; l < auc_pkg::LANES; l++) begin
      if (tail.opaque) begin
        bg[l] = (l == auc_pkg::LANE_ALPHA) ? 8'h00 : tail.comp[l % auc_pkg::COLORS];
      end else if (tail.quo[l][auc_pkg::QUO_W-1]) begin
        bg[l] = auc_pkg::CH_MAX;
      end else begin
        bg[l] = tail.quo[l][auc_pkg::QUO_W-2:0];
      end
    end
  end

  assign m_axis_tvalid_o = pipe_valid[auc_pkg::CELLS];
  assign m_axis_tdata_o  = bg;

  // A finished red division leaves a remainder below the divisor unless it saturated.
  `AUC_ASSERT_IMP(a_rem_below_dvs,
    m_axis_tvalid_o && !tail.opaque && !tail.quo[0][auc_pkg::QUO_W-1],
    tail.rem[0] < tail_dvs_ext, "red remainder not below divisor")

  // Background alpha can never exceed full scale, so its overflow bit stays clear.
  `AUC_ASSERT_IMP(a_alpha_no_ovf,
    m_axis_tvalid_o && !tail.opaque,
    !tail.quo[auc_pkg::LANE_ALPHA][auc_pkg::QUO_W-1], "alpha quotient overflowed")

  // A translucent foreground always leaves a nonzero divisor in the chain.
  `AUC_ASSERT_IMP(a_dvs_nonzero,
    pipe_valid[0] && !pipe[0].opaque,
    pipe[0].dvs != '0, "zero divisor for translucent foreground")

  // A stalled output keeps its pixel in the last cell.
  `AUC_ASSERT_NXT(a_tail_hold,
    m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled output pixel changed")

endmodule

`default_nettype wire
